@@ rtl/multitap_keypad_text_entry_defines.svh @@
// Assertion macros shared by the multi-tap text entry RTL.
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mte_pkg.sv @@
// Types, key codes, characters and decode functions for the multi-tap text entry.
package mte_pkg;

  typedef logic [3:0] key_t;
  typedef logic [7:0] char_t;
  typedef logic [1:0] tap_t;
  typedef logic [3:0] bcd_t;

  localparam int unsigned KEY_COUNT = 9;
  localparam int unsigned SHOWN_CHARS = 32;
  localparam int unsigned BCD_DIGITS = 4;

  localparam key_t NO_KEY      = 4'd15;
  localparam key_t KEY_CLR_LO  = 4'd1;
  localparam key_t KEY_CLR_HI  = 4'd2;
  localparam key_t KEY_MODE_LO = 4'd4;
  localparam key_t KEY_MODE_HI = 4'd5;
  localparam key_t KEY_SPC_LO  = 4'd7;
  localparam key_t KEY_SPC_HI  = 4'd8;

  localparam tap_t TAP_FIRST = 2'd0;
  localparam tap_t TAP_LAST  = 2'd2;

  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_NUL   = 8'h00;
  localparam char_t CHAR_ONE   = 8'h31;

  localparam bcd_t BCD_NINE = 4'd9;

  typedef logic [KEY_COUNT-1:0] keys_t;

  // Lowest pressed key, NO_KEY when none.
  function automatic key_t lowest_key(input keys_t keys);
    key_t k;
    k = NO_KEY;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (keys[i]) k = key_t'(i);
    end
    return k;
  endfunction

  // Highest pressed key, NO_KEY when none.
  function automatic key_t highest_key(input keys_t keys);
    key_t k;
    k = NO_KEY;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (keys[i]) k = key_t'(i);
    end
    return k;
  endfunction

  // Letter for a key at a given tap position.
  function automatic char_t letter_char(input key_t key, input tap_t tap);
    char_t c0;
    char_t c1;
    char_t c2;
    char_t res;
    case (key)
      4'd0: begin c0 = "."; c1 = "Q"; c2 = "Z"; end
      4'd1: begin c0 = "A"; c1 = "B"; c2 = "C"; end
      4'd2: begin c0 = "D"; c1 = "E"; c2 = "F"; end
      4'd3: begin c0 = "G"; c1 = "H"; c2 = "I"; end
      4'd4: begin c0 = "J"; c1 = "K"; c2 = "L"; end
      4'd5: begin c0 = "M"; c1 = "N"; c2 = "O"; end
      4'd6: begin c0 = "P"; c1 = "R"; c2 = "S"; end
      4'd7: begin c0 = "T"; c1 = "U"; c2 = "V"; end
      4'd8: begin c0 = "W"; c1 = "X"; c2 = "Y"; end
      default: begin c0 = CHAR_SPACE; c1 = CHAR_SPACE; c2 = CHAR_SPACE; end
    endcase
    case (tap)
      2'd0:    res = c0;
      2'd1:    res = c1;
      default: res = c2;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/mte_in_if.sv @@
// Key scan channel: valid/ready handshake carrying one nine-key scan.
interface mte_in_if;
  logic                  valid;
  logic                  ready;
  logic [8:0]            keys_pressed;

  modport source (output valid, output keys_pressed, input ready);
  modport sink   (input valid, input keys_pressed, output ready);
endinterface

@@ rtl/mte_out_if.sv @@
// Result channel: valid/ready handshake carrying the line, cursor, mode and press count.
interface mte_out_if;
  logic              valid;
  logic              ready;
  logic [63:0]       line_chars_0_7;
  logic [63:0]       line_chars_8_15;
  logic [63:0]       line_chars_16_23;
  logic [63:0]       line_chars_24_31;
  logic signed [5:0] cursor_column;
  logic              letter_mode;
  logic [3:0]        presses_thousands;
  logic [3:0]        presses_hundreds;
  logic [3:0]        presses_tens;
  logic [3:0]        presses_ones;

  modport source (output valid, output line_chars_0_7, output line_chars_8_15,
                  output line_chars_16_23, output line_chars_24_31,
                  output cursor_column, output letter_mode,
                  output presses_thousands, output presses_hundreds,
                  output presses_tens, output presses_ones, input ready);
  modport sink   (input valid, input line_chars_0_7, input line_chars_8_15,
                  input line_chars_16_23, input line_chars_24_31,
                  input cursor_column, input letter_mode,
                  input presses_thousands, input presses_hundreds,
                  input presses_tens, input presses_ones, output ready);
endinterface

@@ rtl/multitap_keypad_text_entry.sv @@
// Multi-tap keypad text entry: key scan in, text line, cursor, mode and press count out.
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   keys_pressed[8:0]
//   out_chan  out  valid/ready   4 x 64-bit line chars, cursor, mode, 4 BCD digits
//
// One scan per cycle while the result side takes results; an accepted scan passes the
// input register, then the decode/update stage that loads the result register.
// The whole line updates at once: clear, one-column scroll and the cursor write
// are parallel per-column muxes.
// Synchronous active-low reset: line to spaces, cursor -1, letter mode, count 0.
// A stalled result holds the result register; the input register takes a scan
// only while it is empty, then holds that scan until it is processed.
`include "multitap_keypad_text_entry_defines.svh"

module multitap_keypad_text_entry #(
  parameter int LINE_LENGTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  mte_in_if.sink     in_chan,
  mte_out_if.source  out_chan
);

  localparam int IDX_W = $clog2(LINE_LENGTH);
  localparam int CUR_W = IDX_W + 1;
  localparam int SHOWN = mte_pkg::SHOWN_CHARS;

  // Input stage
  logic                 in_v_r;
  mte_pkg::keys_t       keys_r;

  // Block state
  mte_pkg::char_t       line_r   [LINE_LENGTH];
  mte_pkg::char_t       line_nxt [LINE_LENGTH];
  logic signed [CUR_W-1:0] cursor_r, cursor_nxt;
  mte_pkg::key_t        prev_key_r, prev_key_nxt;
  mte_pkg::tap_t        tap_r, tap_nxt;
  mte_pkg::char_t       pending_r, pending_nxt;
  logic                 letter_r, letter_nxt;
  mte_pkg::bcd_t        cnt_r   [mte_pkg::BCD_DIGITS];
  mte_pkg::bcd_t        cnt_nxt [mte_pkg::BCD_DIGITS];

  // Result stage
  logic                 out_v_r;
  logic [SHOWN*8-1:0]   out_line_r;
  logic [SHOWN*8-1:0]   shown_nxt;
  logic [5:0]           out_col_r;
  logic                 out_letter_r;
  mte_pkg::bcd_t        out_cnt_r [mte_pkg::BCD_DIGITS];

  // Decode
  mte_pkg::key_t        low_key, high_key;
  logic                 any_key, is_clear, is_mode, is_space;
  logic                 inc_en, count_en, scroll;
  logic                 process;
  logic                 carry;
  logic signed [31:0]   cur_wide;

  assign process       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || process;

  assign low_key  = mte_pkg::lowest_key(keys_r);
  assign high_key = mte_pkg::highest_key(keys_r);
  assign any_key  = (keys_r != '0);
  assign is_clear = (low_key == mte_pkg::KEY_CLR_LO)  && (high_key == mte_pkg::KEY_CLR_HI);
  assign is_mode  = (low_key == mte_pkg::KEY_MODE_LO) && (high_key == mte_pkg::KEY_MODE_HI);
  assign is_space = (low_key == mte_pkg::KEY_SPC_LO)  && (high_key == mte_pkg::KEY_SPC_HI);

  // Action decode
  always_comb begin
    prev_key_nxt = prev_key_r;
    tap_nxt      = tap_r;
    pending_nxt  = pending_r;
    letter_nxt   = letter_r;
    inc_en       = 1'b0;
    count_en     = 1'b0;
    if (is_clear) begin
      prev_key_nxt = mte_pkg::NO_KEY;
      tap_nxt      = mte_pkg::TAP_FIRST;
      count_en     = 1'b1;
    end else if (is_mode) begin
      letter_nxt = !letter_r;
      count_en   = 1'b1;
    end else if (is_space) begin
      prev_key_nxt = mte_pkg::NO_KEY;
      tap_nxt      = mte_pkg::TAP_FIRST;
      pending_nxt  = mte_pkg::CHAR_SPACE;
      inc_en       = 1'b1;
      count_en     = 1'b1;
    end else if (any_key) begin
      count_en = 1'b1;
      if (letter_r) begin
        if (low_key != prev_key_r) begin
          prev_key_nxt = low_key;
          tap_nxt      = mte_pkg::TAP_FIRST;
          inc_en       = 1'b1;
        end else begin
          tap_nxt = (tap_r == mte_pkg::TAP_LAST) ? mte_pkg::TAP_FIRST : tap_r + 2'd1;
        end
        pending_nxt = mte_pkg::letter_char(low_key, tap_nxt);
      end else begin
        pending_nxt = mte_pkg::CHAR_ONE + {4'd0, low_key};
        inc_en      = 1'b1;
      end
    end
  end

  // Cursor: set before the first column on clear, advance, and scroll the line when it runs past the last column
  always_comb begin
    scroll = inc_en && (cursor_r == CUR_W'(LINE_LENGTH - 1));
    if (is_clear) begin
      cursor_nxt = '1;
    end else if (inc_en && !scroll) begin
      cursor_nxt = cursor_r + CUR_W'(1);
    end else begin
      cursor_nxt = cursor_r;
    end
  end

  // Line: clear, shift left one column, then write the pending char at the cursor
  always_comb begin
    for (int j = 0; j < LINE_LENGTH; j++) begin
      if (is_clear) begin
        line_nxt[j] = mte_pkg::CHAR_SPACE;
      end else if (scroll && (j < LINE_LENGTH - 1)) begin
        line_nxt[j] = line_r[(j + 1) % LINE_LENGTH];
      end else begin
        line_nxt[j] = line_r[j];
      end
      if (!cursor_nxt[CUR_W-1] && (cursor_nxt[IDX_W-1:0] == IDX_W'(j))) begin
        line_nxt[j] = pending_nxt;
      end
    end
  end

  // Press count as BCD digits, wrapping at 9999
  always_comb begin
    carry = count_en;
    for (int d = 0; d < mte_pkg::BCD_DIGITS; d++) begin
      if (carry) begin
        if (cnt_r[d] == mte_pkg::BCD_NINE) begin
          cnt_nxt[d] = '0;
        end else begin
          cnt_nxt[d] = cnt_r[d] + 4'd1;
          carry      = 1'b0;
        end
      end else begin
        cnt_nxt[d] = cnt_r[d];
      end
    end
  end

  // Shown characters: columns past the line end read as spaces
  for (genvar c = 0; c < SHOWN; c++) begin : g_shown
    if (c < LINE_LENGTH) begin : g_col
      assign shown_nxt[c*8 +: 8] = line_nxt[c];
    end else begin : g_pad
      assign shown_nxt[c*8 +: 8] = mte_pkg::CHAR_SPACE;
    end
  end

  assign cur_wide = 32'(cursor_nxt);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      keys_r <= in_chan.keys_pressed;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LINE_LENGTH; j++) line_r[j] <= mte_pkg::CHAR_SPACE;
      cursor_r   <= '1;
      prev_key_r <= mte_pkg::NO_KEY;
      tap_r      <= mte_pkg::TAP_FIRST;
      pending_r  <= mte_pkg::CHAR_NUL;
      letter_r   <= 1'b1;
      for (int d = 0; d < mte_pkg::BCD_DIGITS; d++) cnt_r[d] <= '0;
    end else if (process) begin
      for (int j = 0; j < LINE_LENGTH; j++) line_r[j] <= line_nxt[j];
      cursor_r   <= cursor_nxt;
      prev_key_r <= prev_key_nxt;
      tap_r      <= tap_nxt;
      pending_r  <= pending_nxt;
      letter_r   <= letter_nxt;
      for (int d = 0; d < mte_pkg::BCD_DIGITS; d++) cnt_r[d] <= cnt_nxt[d];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (process) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_line_r   <= shown_nxt;
      out_col_r    <= cur_wide[5:0];
      out_letter_r <= letter_nxt;
      for (int d = 0; d < mte_pkg::BCD_DIGITS; d++) out_cnt_r[d] <= cnt_nxt[d];
    end
  end

  assign out_chan.valid             = out_v_r;
  assign out_chan.line_chars_0_7    = out_line_r[63:0];
  assign out_chan.line_chars_8_15   = out_line_r[127:64];
  assign out_chan.line_chars_16_23  = out_line_r[191:128];
  assign out_chan.line_chars_24_31  = out_line_r[255:192];
  assign out_chan.cursor_column     = out_col_r;
  assign out_chan.letter_mode       = out_letter_r;
  assign out_chan.presses_ones      = out_cnt_r[0];
  assign out_chan.presses_tens      = out_cnt_r[1];
  assign out_chan.presses_hundreds  = out_cnt_r[2];
  assign out_chan.presses_thousands = out_cnt_r[3];

  // A clear leaves the cursor before the first column
  `MTE_ASSERT_NEXT(a_clear_cursor, process && is_clear, cursor_r == '1, "clear left cursor set")
  // An empty scan changes neither cursor nor count
  `MTE_ASSERT_NEXT(a_idle_scan, process && !any_key,
    (cursor_r == $past(cursor_r)) && (cnt_r[0] == $past(cnt_r[0])), "empty scan changed state")
  // A held scan is never dropped while the result side is stalled
  `MTE_ASSERT_NEXT(a_hold_scan, in_v_r && !process, in_v_r && $stable(keys_r),
    "pending scan lost under stall")
  // The cursor never sits past the last column
  `MTE_ASSERT_NOW(a_cursor_range, 1'b1,
    cursor_r == '1 || (!cursor_r[CUR_W-1] && cursor_r <= CUR_W'(LINE_LENGTH - 1)),
    "cursor out of range")

endmodule
